@@ design/s3tc_pkg.sv @@
// Shared types, constants and helper functions of the S3TC block decoder.
package s3tc_pkg;

  typedef enum logic [2:0] {
    MODE_DXT1 = 3'd0,
    MODE_DXT2 = 3'd1,
    MODE_DXT3 = 3'd2,
    MODE_DXT4 = 3'd3,
    MODE_DXT5 = 3'd4
  } mode_e;

  // Configuration map: register index taken from paddr bit 2.
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_MODE = 1'b0;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned MOD_W      = 15;
  localparam int unsigned LANES      = 4;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = 8 / DIV_BITS;
  localparam int unsigned LANE_DEPTH = DIV_STAGES + 1;

  typedef struct packed {
    logic [63:0]        block_lo;
    logic [63:0]        block_hi;
    logic [COORD_W-1:0] block_col;
    logic [COORD_W-1:0] block_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      pixel0;
    logic [31:0]      pixel1;
    logic [31:0]      pixel2;
    logic [31:0]      pixel3;
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
    logic             last_row;
  } row_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } texel_t;

  typedef struct packed {
    logic dxt1;
    logic expl;
    logic premul;
    logic three;
  } fmt_t;

  typedef struct packed {
    rgb_t [3:0]      col;
    logic [7:0][7:0] alpha;
    fmt_t            fmt;
  } pal_t;

  // Row tag that travels alongside the lanes.
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
    logic             last_row;
  } tag_t;

  // One colour channel inside the un-premultiply divider.
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] rem;
    logic [7:0] nlo;
    logic [7:0] quo;
    logic       sat;
    logic       bypass;
  } chan_t;

  typedef struct packed {
    logic [7:0]      a;
    chan_t [2:0]     ch;
  } lane_st_t;

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t t;
    t.r = {v[15:11], v[15:13]};
    t.g = {v[10:5], v[10:9]};
    t.b = {v[4:0], v[4:2]};
    return t;
  endfunction

  // Division by three through a reciprocal, exact for x up to 766.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = x * 10'd683;
    return p[18:11];
  endfunction

  // Division by seven, exact for x up to 1788.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = x * 12'd2341;
    return p[21:14];
  endfunction

  // Division by five, exact for x up to 1278.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = x * 12'd3277;
    return p[21:14];
  endfunction

  // Six steps of a restoring remainder against m, most significant bit first.
  function automatic logic [COORD_W-1:0] mod_steps(input logic [COORD_W-1:0] r,
                                                  input logic [5:0] bits,
                                                  input logic [MOD_W-1:0] m);
    logic [COORD_W:0]   w;
    logic [COORD_W-1:0] acc;
    acc = r;
    for (int i = 5; i >= 0; i--) begin
      w = {acc, bits[i]};
      if ({2'b00, w} >= m) begin
        w = w - m[COORD_W:0];
      end
      acc = w[COORD_W-1:0];
    end
    return acc;
  endfunction

  // One quotient bit of the long division of c*255 by alpha.
  function automatic chan_t div_step(input chan_t ch, input logic [7:0] a);
    logic [8:0] r2;
    chan_t      o;
    o     = ch;
    r2    = {ch.rem, ch.nlo[7]};
    o.nlo = {ch.nlo[6:0], 1'b0};
    if (r2 >= {1'b0, a}) begin
      o.rem = 8'(r2 - {1'b0, a});
      o.quo = {ch.quo[6:0], 1'b1};
    end else begin
      o.rem = r2[7:0];
      o.quo = {ch.quo[6:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ design/s3tc_in_if.sv @@
// Block input channel: valid/ready handshake carrying one compressed block.
interface s3tc_in_if;
  import s3tc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/s3tc_out_if.sv @@
// Row output channel: valid/ready handshake carrying one decoded texel row.
interface s3tc_out_if;
  import s3tc_pkg::*;
  logic      valid;
  logic      ready;
  row_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/s3tc_front.sv @@
// Block register, palette construction and row sequencer feeding the lanes.
module s3tc_front #(
  parameter int unsigned MAX_DIM_BLOCKS = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [2:0]                           mode_i,
  s3tc_in_if.sink                              blk_i,
  output s3tc_pkg::pal_t                       pal_o,
  output logic [s3tc_pkg::LANES-1:0][1:0]      cidx_o,
  output logic [s3tc_pkg::LANES-1:0][3:0]      acode_o,
  output s3tc_pkg::tag_t                       tag_o
);
  import s3tc_pkg::*;

  localparam logic [MOD_W-1:0] MAXD = MOD_W'(MAX_DIM_BLOCKS);

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } sum3_t;

  typedef struct packed {
    fmt_t               fmt;
    rgb_t               p0;
    rgb_t               p1;
    rgb_t               half;
    sum3_t              s2;
    sum3_t              s3;
    logic [31:0]        cmask;
    logic [63:0]        abits;
    logic [5:0][10:0]   asum;
    logic               alt;
    logic [COORD_W-1:0] col_part;
    logic [COORD_W-1:0] row_part;
    logic [5:0]         col_low;
    logic [5:0]         row_low;
  } held_t;

  function automatic logic [9:0] wsum(input logic [7:0] x, input logic [7:0] y);
    return {1'b0, x, 1'b0} + {2'b00, y} + 10'd1;
  endfunction

  function automatic logic [7:0] hsum(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8:1];
  endfunction

  held_t                     held_q, held_d;
  logic                      blk_vld_q;
  logic [1:0]                row_q;
  pal_t                      pal_q, pal_d;
  logic [LANES-1:0][1:0]     cidx_q, cidx_d;
  logic [LANES-1:0][3:0]     acode_q, acode_d;
  tag_t                      tag_q, tag_d;
  logic                      accept;
  logic                      done;

  assign done        = en_i && blk_vld_q && (row_q == 2'd3);
  assign blk_i.ready = !blk_vld_q || done;
  assign accept      = blk_i.valid && blk_i.ready;

  // Endpoint expansion and the weighted sums are formed as the block arrives.
  always_comb begin
    logic [63:0] cword;
    logic [7:0]  a0;
    logic [7:0]  a1;
    held_d.fmt.dxt1   = (mode_i == MODE_DXT1);
    held_d.fmt.expl   = (mode_i == MODE_DXT2) || (mode_i == MODE_DXT3);
    held_d.fmt.premul = (mode_i == MODE_DXT2) || (mode_i == MODE_DXT4);
    cword             = held_d.fmt.dxt1 ? blk_i.data.block_lo : blk_i.data.block_hi;
    held_d.fmt.three  = held_d.fmt.dxt1 && (cword[31:16] >= cword[15:0]);
    held_d.p0         = expand565(cword[15:0]);
    held_d.p1         = expand565(cword[31:16]);
    held_d.half.r     = hsum(held_d.p0.r, held_d.p1.r);
    held_d.half.g     = hsum(held_d.p0.g, held_d.p1.g);
    held_d.half.b     = hsum(held_d.p0.b, held_d.p1.b);
    held_d.s2.r       = wsum(held_d.p0.r, held_d.p1.r);
    held_d.s2.g       = wsum(held_d.p0.g, held_d.p1.g);
    held_d.s2.b       = wsum(held_d.p0.b, held_d.p1.b);
    held_d.s3.r       = wsum(held_d.p1.r, held_d.p0.r);
    held_d.s3.g       = wsum(held_d.p1.g, held_d.p0.g);
    held_d.s3.b       = wsum(held_d.p1.b, held_d.p0.b);
    held_d.cmask      = cword[63:32];
    held_d.abits      = blk_i.data.block_lo;
    a0                = blk_i.data.block_lo[7:0];
    a1                = blk_i.data.block_lo[15:8];
    held_d.alt        = (a1 < a0);
    for (int i = 1; i <= 6; i++) begin
      if (held_d.alt) begin
        held_d.asum[i-1] = 11'((7 - i) * a0 + i * a1 + 3);
      end else if (i <= 4) begin
        held_d.asum[i-1] = 11'((5 - i) * a0 + i * a1 + 3);
      end else begin
        held_d.asum[i-1] = '0;
      end
    end
    held_d.col_part = mod_steps('0, blk_i.data.block_col[11:6], MAXD);
    held_d.row_part = mod_steps('0, blk_i.data.block_row[11:6], MAXD);
    held_d.col_low  = blk_i.data.block_col[5:0];
    held_d.row_low  = blk_i.data.block_row[5:0];
  end

  // Palettes, the indices of the current row and its row tag.
  always_comb begin
    logic [7:0]  cm_row;
    logic [15:0] nib_row;
    logic [11:0] code_row;
    logic [5:0]  code_base;
    pal_d.fmt    = held_q.fmt;
    pal_d.col[0] = held_q.p0;
    pal_d.col[1] = held_q.p1;
    if (held_q.fmt.three) begin
      pal_d.col[2] = held_q.half;
      pal_d.col[3] = '0;
    end else begin
      pal_d.col[2] = '{r: div3(held_q.s2.r), g: div3(held_q.s2.g), b: div3(held_q.s2.b)};
      pal_d.col[3] = '{r: div3(held_q.s3.r), g: div3(held_q.s3.g), b: div3(held_q.s3.b)};
    end
    pal_d.alpha[0] = held_q.abits[7:0];
    pal_d.alpha[1] = held_q.abits[15:8];
    for (int i = 1; i <= 6; i++) begin
      if (held_q.alt) begin
        pal_d.alpha[i+1] = div7(held_q.asum[i-1]);
      end else if (i <= 4) begin
        pal_d.alpha[i+1] = div5(held_q.asum[i-1]);
      end else if (i == 5) begin
        pal_d.alpha[i+1] = 8'h00;
      end else begin
        pal_d.alpha[i+1] = 8'hFF;
      end
    end

    cm_row    = held_q.cmask[{row_q, 3'b000} +: 8];
    nib_row   = held_q.abits[{row_q, 4'b0000} +: 16];
    code_base = 6'd16 + {1'b0, row_q, 3'b000} + {2'b00, row_q, 2'b00};
    code_row  = held_q.abits[code_base +: 12];
    for (int l = 0; l < LANES; l++) begin
      cidx_d[l]  = cm_row[2*l +: 2];
      acode_d[l] = held_q.fmt.expl ? nib_row[4*l +: 4] : {1'b0, code_row[3*l +: 3]};
    end

    tag_d.vld      = blk_vld_q;
    tag_d.pixel_x  = {mod_steps(held_q.col_part, held_q.col_low, MAXD), 2'b00};
    tag_d.pixel_y  = {mod_steps(held_q.row_part, held_q.row_low, MAXD), row_q};
    tag_d.last_row = (row_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= 1'b0;
      row_q     <= 2'd0;
      tag_q     <= '0;
    end else begin
      if (accept) begin
        blk_vld_q <= 1'b1;
      end else if (done) begin
        blk_vld_q <= 1'b0;
      end
      // The counter wraps back to the top row as the fourth row leaves.
      if (en_i && blk_vld_q) begin
        row_q <= row_q + 2'd1;
      end
      if (en_i) begin
        tag_q <= tag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
    if (en_i) begin
      pal_q   <= pal_d;
      cidx_q  <= cidx_d;
      acode_q <= acode_d;
    end
  end

  assign pal_o   = pal_q;
  assign cidx_o  = cidx_q;
  assign acode_o = acode_q;
  assign tag_o   = tag_q;

  a_idle_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blk_vld_q |-> row_q == 2'd0)
    else $error("row counter moved without a block held");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_i.valid && blk_i.ready |=> blk_vld_q && row_q == 2'd0)
    else $error("accepted block does not start at the top row");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> tag_q.vld && tag_q.last_row)
    else $error("final row of a block not tagged as last");

endmodule

@@ design/s3tc_lane.sv @@
// One texel lane: palette lookup, alpha selection and the un-premultiply divider.
module s3tc_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  s3tc_pkg::pal_t   pal_i,
  input  logic [1:0]       cidx_i,
  input  logic [3:0]       acode_i,
  output s3tc_pkg::texel_t texel_o
);
  import s3tc_pkg::*;

  function automatic chan_t setup(input logic [7:0] c, input logic [7:0] a,
                                  input logic premul);
    logic [15:0] n;
    chan_t       ch;
    n         = {c, 8'h00} - {8'h00, c};
    ch.c      = c;
    ch.rem    = n[15:8];
    ch.nlo    = n[7:0];
    ch.quo    = '0;
    // With c above alpha the quotient would reach 256 or more.
    ch.sat    = (c > a);
    ch.bypass = !premul || (a == 8'h00);
    return ch;
  endfunction

  function automatic lane_st_t advance(input lane_st_t s);
    lane_st_t o;
    o = s;
    for (int j = 0; j < DIV_BITS; j++) begin
      for (int k = 0; k < 3; k++) begin
        o.ch[k] = div_step(o.ch[k], s.a);
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] finish(input chan_t ch);
    logic [7:0] v;
    priority if (ch.bypass) begin
      v = ch.c;
    end else if (ch.sat) begin
      v = 8'hFF;
    end else begin
      v = ch.quo;
    end
    return v;
  endfunction

  lane_st_t st_q [LANE_DEPTH];
  lane_st_t st_d [LANE_DEPTH];

  always_comb begin
    rgb_t       c;
    logic [7:0] a;
    c = pal_i.col[cidx_i];
    priority if (pal_i.fmt.dxt1) begin
      a = (pal_i.fmt.three && (cidx_i == 2'd3)) ? 8'h00 : 8'hFF;
    end else if (pal_i.fmt.expl) begin
      a = {acode_i, acode_i};
    end else begin
      a = pal_i.alpha[acode_i[2:0]];
    end
    st_d[0].a     = a;
    st_d[0].ch[2] = setup(c.r, a, pal_i.fmt.premul);
    st_d[0].ch[1] = setup(c.g, a, pal_i.fmt.premul);
    st_d[0].ch[0] = setup(c.b, a, pal_i.fmt.premul);
    for (int k = 1; k < LANE_DEPTH; k++) begin
      st_d[k] = advance(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < LANE_DEPTH; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign texel_o.a = st_q[LANE_DEPTH-1].a;
  assign texel_o.r = finish(st_q[LANE_DEPTH-1].ch[2]);
  assign texel_o.g = finish(st_q[LANE_DEPTH-1].ch[1]);
  assign texel_o.b = finish(st_q[LANE_DEPTH-1].ch[0]);

endmodule

@@ design/s3tc_merge.sv @@
// Row tag delay line and output register that packs the four lane texels.
module s3tc_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s3tc_pkg::tag_t                      tag_i,
  input  s3tc_pkg::texel_t [s3tc_pkg::LANES-1:0] texel_i,
  output logic                                en_o,
  s3tc_out_if.source                          row_o
);
  import s3tc_pkg::*;

  tag_t [LANE_DEPTH-1:0] tag_q;
  logic                  out_vld_q;
  row_item_t             out_q, out_d;

  // The whole pipeline advances whenever the output register can move.
  assign en_o = !out_vld_q || row_o.ready;

  always_comb begin
    out_d.pixel0   = {texel_i[0].a, texel_i[0].b, texel_i[0].g, texel_i[0].r};
    out_d.pixel1   = {texel_i[1].a, texel_i[1].b, texel_i[1].g, texel_i[1].r};
    out_d.pixel2   = {texel_i[2].a, texel_i[2].b, texel_i[2].g, texel_i[2].r};
    out_d.pixel3   = {texel_i[3].a, texel_i[3].b, texel_i[3].g, texel_i[3].r};
    out_d.pixel_x  = tag_q[LANE_DEPTH-1].pixel_x;
    out_d.pixel_y  = tag_q[LANE_DEPTH-1].pixel_y;
    out_d.last_row = tag_q[LANE_DEPTH-1].last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_o) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < LANE_DEPTH; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      out_vld_q <= tag_q[LANE_DEPTH-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_q <= out_d;
    end
  end

  assign row_o.valid = out_vld_q;
  assign row_o.data  = out_q;

  a_row_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_o && tag_q[LANE_DEPTH-1].vld |=> out_vld_q)
    else $error("row left the lanes but no transfer was offered");

endmodule

@@ design/s3tc_block_decoder.sv @@
// Top level of the S3TC block decoder: mode register, front end, four lanes, merge.
//
//   channel  dir  handshake          payload
//   blk_i    in   valid/ready        block_lo, block_hi, block_col, block_row
//   row_o    out  valid/ready        pixel0..pixel3, pixel_x, pixel_y, last_row
//   apb      in   psel/penable       mode at byte address 0, pready always high
//
// A block yields four row transfers; while row_o does not stall, they leave one per cycle
// and the row sequencer in the front end feeds one texel row per cycle to four lanes.
// A row passes the palette register, lane setup, divider (four stages), output register.
// Reset clears the mode to DXT1 and empties the pipeline; no clearing pass.
// A stall on row_o freezes every stage; an empty block register still takes a block.
module s3tc_block_decoder #(
  parameter int unsigned MAX_DIM_BLOCKS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  s3tc_in_if.sink                       blk_i,
  s3tc_out_if.source                    row_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [s3tc_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);
  import s3tc_pkg::*;

  logic [2:0]            mode_q;
  logic                  cfg_wr;
  logic                  en;
  pal_t                  pal;
  logic [LANES-1:0][1:0] cidx;
  logic [LANES-1:0][3:0] acode;
  tag_t                  tag;
  texel_t [LANES-1:0]    texel;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o && (paddr_i[2] == REG_MODE);
  assign prdata_o = (paddr_i[2] == REG_MODE) ? {29'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DXT1;
    end else if (cfg_wr) begin
      mode_q <= pwdata_i[2:0];
    end
  end

  s3tc_front #(
    .MAX_DIM_BLOCKS (MAX_DIM_BLOCKS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .mode_i  (mode_q),
    .blk_i   (blk_i),
    .pal_o   (pal),
    .cidx_o  (cidx),
    .acode_o (acode),
    .tag_o   (tag)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    s3tc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .pal_i   (pal),
      .cidx_i  (cidx[l]),
      .acode_i (acode[l]),
      .texel_o (texel[l])
    );
  end

  s3tc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .texel_i (texel),
    .en_o    (en),
    .row_o   (row_o)
  );

endmodule
